// File: hdl/i2ra_pkg.sv
`default_nettype none
package i2ra_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

  localparam logic [5:0] RADIX_RESET = 6'd16;
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] DIGIT_TEN   = 6'd10;

  localparam logic [6:0] CHAR_NUL      = 7'h00;
  localparam logic [6:0] CHAR_MINUS    = 7'h2D;
  localparam logic [6:0] CHAR_ZERO     = 7'h30;
  localparam logic [6:0] CHAR_LETTER_A = 7'h61;

  // register index decoded from paddr[2]
  localparam logic ADDR_RADIX = 1'b0;

  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [5:0] off;
    off = d - DIGIT_TEN;
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + {1'b0, d};
    end else begin
      return CHAR_LETTER_A + {1'b0, off};
    end
  endfunction

endpackage
`default_nettype wire

// File: hdl/integer_to_radix_ascii.sv
// Operation: a bit-serial restoring divider produces each digit as a remainder,
// least significant digit first; a negative number then emits a minus sign.
// Each digit is then read from the store and output, most significant first.
// Throughput: one request at a time; busy is high from accept to the last character.
// Invalid radix: one NUL character flagged last, the cycle after accept.
// Reset: radix returns to 16, digit count and sign flag clear, no output pending.
`default_nettype none
module integer_to_radix_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [VALUE_WIDTH-1:0] number,
  output logic                               busy,
  output logic                               strobe,
  output logic [6:0]                         character,
  output logic                               last_char,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import i2ra_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W = $clog2(VALUE_WIDTH);
  localparam logic [IDX_W-1:0] BIT_LAST = IDX_W'(VALUE_WIDTH - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  state_t state, state_next;
  logic [5:0]             radix;
  logic [VALUE_WIDTH-1:0] mag, mag_next;
  logic [5:0]             rem, rem_next;
  logic [IDX_W-1:0]       bit_cnt, bit_cnt_next;
  logic                   qnz, qnz_next;
  logic [CNT_W-1:0]       digit_count, digit_count_next;
  logic                   negative_flag, negative_flag_next;
  logic [IDX_W-1:0]       rd_ptr, rd_ptr_next;
  logic                   strobe_next, last_char_next;
  logic [6:0]             character_next;

  logic [5:0] digit_store [VALUE_WIDTH];
  logic [5:0] rd_data;
  logic       store_we;

  logic [VALUE_WIDTH-1:0] num_u;
  logic [6:0]             rem_sh, rem_new;
  logic                   q_bit, radix_ok, cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == ADDR_RADIX) ? {26'd0, radix} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr && paddr[2] == ADDR_RADIX) begin
      radix <= pwdata[5:0];
    end
  end

  // one quotient bit per cycle
  assign num_u    = number;
  assign rem_sh   = {rem, mag[VALUE_WIDTH-1]};
  assign q_bit    = rem_sh >= {1'b0, radix};
  assign rem_new  = q_bit ? (rem_sh - {1'b0, radix}) : rem_sh;
  assign radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign busy     = (state != ST_IDLE);

  always_comb begin
    state_next         = state;
    mag_next           = mag;
    rem_next           = rem;
    bit_cnt_next       = bit_cnt;
    qnz_next           = qnz;
    digit_count_next   = digit_count;
    negative_flag_next = negative_flag;
    rd_ptr_next        = rd_ptr;
    strobe_next        = 1'b0;
    character_next     = character;
    last_char_next     = last_char;
    store_we           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (!radix_ok) begin
            strobe_next    = 1'b1;
            character_next = CHAR_NUL;
            last_char_next = 1'b1;
          end else begin
            negative_flag_next = number[VALUE_WIDTH-1];
            mag_next           = number[VALUE_WIDTH-1] ? (~num_u + 1'b1) : num_u;
            rem_next           = 6'd0;
            bit_cnt_next       = '0;
            qnz_next           = 1'b0;
            digit_count_next   = '0;
            state_next         = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        mag_next = {mag[VALUE_WIDTH-2:0], q_bit};
        rem_next = rem_new[5:0];
        qnz_next = qnz | q_bit;
        if (bit_cnt == BIT_LAST) begin
          // digit done: remainder goes to the store, quotient stays in mag
          store_we         = 1'b1;
          digit_count_next = digit_count + 1'b1;
          rd_ptr_next      = digit_count[IDX_W-1:0];
          rem_next         = 6'd0;
          qnz_next         = 1'b0;
          bit_cnt_next     = '0;
          if (!(qnz | q_bit) || digit_count == CNT_LAST) begin
            state_next = negative_flag ? ST_SIGN : ST_READ;
          end
        end else begin
          bit_cnt_next = bit_cnt + 1'b1;
        end
      end
      ST_SIGN: begin
        strobe_next    = 1'b1;
        character_next = CHAR_MINUS;
        last_char_next = 1'b0;
        state_next     = ST_READ;
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        strobe_next    = 1'b1;
        character_next = digit_char(rd_data);
        last_char_next = (rd_ptr == '0);
        if (rd_ptr == '0) begin
          state_next = ST_IDLE;
        end else begin
          rd_ptr_next = rd_ptr - 1'b1;
          state_next  = ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      strobe        <= 1'b0;
      digit_count   <= '0;
      negative_flag <= 1'b0;
    end else begin
      state         <= state_next;
      strobe        <= strobe_next;
      digit_count   <= digit_count_next;
      negative_flag <= negative_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    mag       <= mag_next;
    rem       <= rem_next;
    bit_cnt   <= bit_cnt_next;
    qnz       <= qnz_next;
    rd_ptr    <= rd_ptr_next;
    character <= character_next;
    last_char <= last_char_next;
  end

  // digit store, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (store_we) begin
      digit_store[digit_count[IDX_W-1:0]] <= rem_new[5:0];
    end
    rd_data <= digit_store[rd_ptr];
  end

  a_done_flags_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && last_char)
    else $error("busy fell without a final character");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(VALUE_WIDTH))
    else $error("digit count beyond store depth");

  a_bad_radix: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !radix_ok |=> strobe && last_char && character == CHAR_NUL)
    else $error("invalid radix did not give a single NUL");

endmodule
`default_nettype wire
